// File: design/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants for the three-way color partition block.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

  localparam logic [7:0] TAG_BLUE  = 8'h61;
  localparam logic [7:0] TAG_GREEN = 8'h76;

  localparam logic [1:0] REGION_BLUE  = 2'd0;
  localparam logic [1:0] REGION_GREEN = 2'd1;
  localparam logic [1:0] REGION_RED   = 2'd2;

  typedef struct packed {
    logic [7:0]  color;
    logic [15:0] height;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0]  out_color;
    logic [15:0] out_height;
    logic [1:0]  region;
    logic [6:0]  blue_count;
    logic [6:0]  red_start;
    logic        overflow;
    logic        last_result;
  } out_pl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRD,
    ST_PEVAL,
    ST_PSW1,
    ST_PSW2,
    ST_ERD,
    ST_EOUT
  } state_t;

endpackage

// File: design/tcp_ifs.sv
// ----------------------------------------------------------------------------
// tcp_ifs
// Valid/ready channels for record beats in and partitioned record beats out.
// ----------------------------------------------------------------------------
interface tcp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  color_code;
  logic [15:0] height;
  logic        last_item;

  modport source (output valid, output color_code, output height, output last_item,
                  input ready);
  modport sink (input valid, input color_code, input height, input last_item,
                output ready);
endinterface

interface tcp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_color;
  logic [15:0] out_height;
  logic [1:0]  region;
  logic [6:0]  blue_count;
  logic [6:0]  red_start;
  logic        overflow;
  logic        last_result;

  modport source (output valid, output out_color, output out_height, output region,
                  output blue_count, output red_start, output overflow,
                  output last_result, input ready);
  modport sink (input valid, input out_color, input out_height, input region,
                input blue_count, input red_start, input overflow,
                input last_result, output ready);
endinterface

// File: design/tcp_ram.sv
// ----------------------------------------------------------------------------
// tcp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/tcp_ctrl.sv
// ----------------------------------------------------------------------------
// tcp_ctrl
// Sequencer: loads records into the store, runs the lo/mid/hi partition as
// read-evaluate-swap steps on the store, then streams the store out.
// ----------------------------------------------------------------------------
module tcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  tcp_in_if.sink            in_ch,
  tcp_out_if.source         out_ch,
  output tcp_pkg::mem_req_t mem_req,
  input  tcp_pkg::rec_t     mem_rdata
);
  import tcp_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] oth_r, oth_nxt;
  logic             blue_r, blue_nxt;
  rec_t             cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_pl_t          out_pl_r, out_pl_nxt;

  logic [CNT_W-1:0] hi_m1;
  logic [CNT_W-1:0] pos;
  logic             room;

  assign hi_m1 = hi_r - CNT_W'(1);
  assign pos   = CNT_W'(idx_r);
  assign room  = cnt_r < MAX_CNT;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    oth_nxt       = oth_r;
    blue_nxt      = blue_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    out_pl_nxt    = out_pl_r;
    out_valid_nxt = out_valid_r;
    mem_req       = '0;
    in_ch.ready   = (state_r == ST_LOAD);

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_ch.valid) begin
          if (room) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cnt_r[IDX_W-1:0];
            mem_req.wdata = '{color: in_ch.color_code, height: in_ch.height};
            cnt_nxt       = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_item) begin
            lo_nxt    = '0;
            mid_nxt   = '0;
            hi_nxt    = room ? cnt_r + CNT_W'(1) : cnt_r;
            state_nxt = ST_PRD;
          end
        end
      end
      ST_PRD: begin
        if (mid_r < hi_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = mid_r[IDX_W-1:0];
          state_nxt     = ST_PEVAL;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_ERD;
        end
      end
      ST_PEVAL: begin
        cur_nxt = mem_rdata;
        if (mem_rdata.color == TAG_GREEN) begin
          mid_nxt   = mid_r + CNT_W'(1);
          state_nxt = ST_PRD;
        end else if (mem_rdata.color == TAG_BLUE) begin
          blue_nxt      = 1'b1;
          oth_nxt       = lo_r[IDX_W-1:0];
          mem_req.re    = 1'b1;
          mem_req.raddr = lo_r[IDX_W-1:0];
          state_nxt     = ST_PSW1;
        end else begin
          blue_nxt      = 1'b0;
          oth_nxt       = hi_m1[IDX_W-1:0];
          mem_req.re    = 1'b1;
          mem_req.raddr = hi_m1[IDX_W-1:0];
          state_nxt     = ST_PSW1;
        end
      end
      ST_PSW1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = mid_r[IDX_W-1:0];
        mem_req.wdata = mem_rdata;
        state_nxt     = ST_PSW2;
      end
      ST_PSW2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = oth_r;
        mem_req.wdata = cur_r;
        if (blue_r) begin
          lo_nxt  = lo_r + CNT_W'(1);
          mid_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = hi_m1;
        end
        state_nxt = ST_PRD;
      end
      ST_ERD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r;
        state_nxt     = ST_EOUT;
      end
      ST_EOUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt          = 1'b1;
          out_pl_nxt.out_color   = mem_rdata.color;
          out_pl_nxt.out_height  = mem_rdata.height;
          out_pl_nxt.region      = (pos < lo_r) ? REGION_BLUE :
                                   (pos < hi_r) ? REGION_GREEN : REGION_RED;
          out_pl_nxt.blue_count  = 7'(lo_r);
          out_pl_nxt.red_start   = 7'(hi_r);
          out_pl_nxt.overflow    = ovf_r;
          out_pl_nxt.last_result = (pos + CNT_W'(1) == cnt_r);
          if (pos + CNT_W'(1) == cnt_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_ERD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      lo_r        <= '0;
      mid_r       <= '0;
      hi_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      lo_r        <= lo_nxt;
      mid_r       <= mid_nxt;
      hi_r        <= hi_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oth_r    <= oth_nxt;
    blue_r   <= blue_nxt;
    cur_r    <= cur_nxt;
    out_pl_r <= out_pl_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_color   = out_pl_r.out_color;
  assign out_ch.out_height  = out_pl_r.out_height;
  assign out_ch.region      = out_pl_r.region;
  assign out_ch.blue_count  = out_pl_r.blue_count;
  assign out_ch.red_start   = out_pl_r.red_start;
  assign out_ch.overflow    = out_pl_r.overflow;
  assign out_ch.last_result = out_pl_r.last_result;

endmodule

// File: design/three_way_color_partition_top.sv
// ----------------------------------------------------------------------------
// three_way_color_partition_top
// Collects a set of tagged records, partitions them blue/green/red in place
// and streams them out in the new order with the region boundaries.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one record per beat (color_code, height, last_item). Beats
//   are taken one per cycle while the block is loading. Up to MAX_RECORDS
//   records are stored; further beats are dropped and flag overflow.
//   The beat with last_item set closes the set. Loading then stops and the
//   block partitions the store with lo/mid/hi indices: each step reads one
//   entry (for a green record) or reads and swaps two entries (for blue or
//   red), all through the single store read port. Emission then reads each
//   record back from the store and sends it as one beat on out_ch, with
//   last_result on the final beat. out_ch is registered: a stalled
//   receiver holds the current beat and stops emission; after the last beat
//   is loaded into the output register the block takes the next set while
//   that beat still waits. Reset (rst_n low, synchronous) empties the set
//   and clears the overflow flag and the output valid. The store itself is
//   not cleared.
// ----------------------------------------------------------------------------
module three_way_color_partition_top (
  input logic       clk,
  input logic       rst_n,
  tcp_in_if.sink    in_ch,
  tcp_out_if.source out_ch
);
  import tcp_pkg::*;

  mem_req_t mem_req;
  rec_t     mem_rdata;

  tcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tcp_ram #(
    .DEPTH (MAX_RECORDS),
    .WIDTH ($bits(rec_t)),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: design/tcp_checker.sv
// ----------------------------------------------------------------------------
// tcp_checker
// Port-level checks on the partition block, bound to the top level.
// ----------------------------------------------------------------------------
module tcp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_color,
  input logic [1:0] region,
  input logic [6:0] blue_count,
  input logic [6:0] red_start,
  input logic       overflow,
  input logic       last_result
);
  import tcp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color) && $stable(region))
    else $error("output beat changed while stalled");

  a_region_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((region == REGION_BLUE && out_color == TAG_BLUE) ||
                   (region == REGION_GREEN && out_color == TAG_GREEN) ||
                   (region == REGION_RED && out_color != TAG_BLUE &&
                    out_color != TAG_GREEN)))
    else $error("record emitted in wrong region");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> blue_count <= red_start)
    else $error("region boundaries out of order");

  a_load_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last beat");

  a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_result |=> !out_valid || overflow == $past(overflow))
    else $error("overflow changed within a set");

endmodule

bind three_way_color_partition_top tcp_checker u_tcp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_item),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_color   (out_ch.out_color),
  .region      (out_ch.region),
  .blue_count  (out_ch.blue_count),
  .red_start   (out_ch.red_start),
  .overflow    (out_ch.overflow),
  .last_result (out_ch.last_result)
);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams sets of tagged records into the three-way color partition block
// with random gaps and back-pressure, predicts each partitioned set in order
// and checks every output beat field by field against the prediction.
// ----------------------------------------------------------------------------
module testbench;
  import tcp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TARGET_ITEMS = 230;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    rec_t rec;
    logic last;
  } stim_t;

  logic clk;
  logic rst_n;

  tcp_in_if  in_ch ();
  tcp_out_if out_ch ();

  three_way_color_partition_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_t   record_q[$];
  out_pl_t partitioned_q[$];

  rec_t        rec_store [MAX_RECORDS];
  int unsigned rec_cnt;
  logic        set_dropped;

  int   cyc;
  int   bad_beats;
  int   result_beats;
  int   hold_left;
  logic hold_done;
  logic in_beat_taken;
  logic calm;
  stim_t drv_item;

  always #5 clk = ~clk;

  assign calm = (cyc >= 600) && (cyc < 1400);

  // Partition predictor: store, then lo/mid/hi pass on the closing record.
  task automatic take_record(input rec_t r, input logic last);
    rec_t        tmp;
    out_pl_t     e;
    int unsigned lo, mid, hi, i;
    if (rec_cnt < MAX_RECORDS) begin
      rec_store[rec_cnt] = r;
      rec_cnt++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    lo  = 0;
    mid = 0;
    hi  = rec_cnt;
    while (mid < hi) begin
      if (rec_store[mid].color == TAG_GREEN) begin
        mid++;
      end else if (rec_store[mid].color == TAG_BLUE) begin
        tmp            = rec_store[lo];
        rec_store[lo]  = rec_store[mid];
        rec_store[mid] = tmp;
        lo++;
        mid++;
      end else begin
        tmp               = rec_store[mid];
        rec_store[mid]    = rec_store[hi - 1];
        rec_store[hi - 1] = tmp;
        hi--;
      end
    end
    for (i = 0; i < rec_cnt; i++) begin
      e.out_color   = rec_store[i].color;
      e.out_height  = rec_store[i].height;
      e.region      = (i < lo) ? REGION_BLUE : ((i < hi) ? REGION_GREEN : REGION_RED);
      e.blue_count  = 7'(lo);
      e.red_start   = 7'(hi);
      e.overflow    = set_dropped;
      e.last_result = (i + 1 == rec_cnt);
      partitioned_q.push_back(e);
    end
    rec_cnt     = 0;
    set_dropped = 1'b0;
  endtask

  function automatic logic [7:0] pick_color();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return TAG_BLUE;
    if (r < 70) return TAG_GREEN;
    return 8'($urandom);
  endfunction

  task automatic queue_record(input logic [7:0] c, input logic [15:0] h, input logic last);
    stim_t s;
    s.rec.color  = c;
    s.rec.height = h;
    s.last       = last;
    record_q.push_back(s);
  endtask

  task automatic queue_random_set(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      queue_record(pick_color(), 16'($urandom), i == n - 1);
    end
  endtask

  // Input beat acceptance and prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        take_record({in_ch.color_code, in_ch.height}, in_ch.last_item);
      end
    end
  end

  // Driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat_taken) begin
      if (record_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        drv_item = record_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.color_code <= drv_item.rec.color;
        in_ch.height     <= drv_item.rec.height;
        in_ch.last_item  <= drv_item.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once a few sets have come out.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && result_beats >= 40) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 16);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    out_pl_t got, exp_beat;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_beats <= result_beats + 1;
      got.out_color   = out_ch.out_color;
      got.out_height  = out_ch.out_height;
      got.region      = out_ch.region;
      got.blue_count  = out_ch.blue_count;
      got.red_start   = out_ch.red_start;
      got.overflow    = out_ch.overflow;
      got.last_result = out_ch.last_result;
      if (partitioned_q.size() == 0) begin
        if (bad_beats < 10) begin
          $display("unexpected beat: color %h height %h region %0d", got.out_color,
                   got.out_height, got.region);
        end
        bad_beats <= bad_beats + 1;
      end else begin
        exp_beat = partitioned_q.pop_front();
        if (got.out_color !== exp_beat.out_color || got.out_height !== exp_beat.out_height ||
            got.region !== exp_beat.region || got.blue_count !== exp_beat.blue_count ||
            got.red_start !== exp_beat.red_start || got.overflow !== exp_beat.overflow ||
            got.last_result !== exp_beat.last_result) begin
          if (bad_beats < 10) begin
            $display("mismatch exp: color %h height %h region %0d blue %0d red %0d ovf %b last %b",
                     exp_beat.out_color, exp_beat.out_height, exp_beat.region,
                     exp_beat.blue_count, exp_beat.red_start, exp_beat.overflow,
                     exp_beat.last_result);
            $display("         got: color %h height %h region %0d blue %0d red %0d ovf %b last %b",
                     got.out_color, got.out_height, got.region, got.blue_count,
                     got.red_start, got.overflow, got.last_result);
          end
          bad_beats <= bad_beats + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYCLES) begin
      $display("FAIL three_way_color_partition_top");
      $finish;
    end
  end

  initial begin
    int sets;
    clk              = 1'b0;
    rst_n            = 1'b0;
    cyc              = 0;
    bad_beats        = 0;
    result_beats     = 0;
    rec_cnt          = 0;
    set_dropped      = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.color_code = 8'h00;
    in_ch.height     = 16'h0000;
    in_ch.last_item  = 1'b0;
    out_ch.ready     = 1'b0;

    // Single-record sets and field extremes.
    queue_record(TAG_BLUE, 16'h0000, 1'b1);
    queue_record(TAG_GREEN, 16'hFFFF, 1'b1);
    queue_record(8'h00, 16'h0000, 1'b1);
    queue_record(8'hFF, 16'hFFFF, 1'b1);
    // Mixed set with tags next to the blue and green codes.
    queue_record(8'h60, 16'h1001, 1'b0);
    queue_record(TAG_GREEN, 16'h1002, 1'b0);
    queue_record(TAG_BLUE, 16'h1003, 1'b0);
    queue_record(8'h62, 16'h1004, 1'b0);
    queue_record(8'h75, 16'h1005, 1'b0);
    queue_record(TAG_BLUE, 16'h1006, 1'b0);
    queue_record(8'h77, 16'h1007, 1'b0);
    queue_record(TAG_GREEN, 16'h1008, 1'b1);
    // One-color sets.
    queue_record(8'h80, 16'h5555, 1'b0);
    queue_record(8'h7F, 16'hAAAA, 1'b0);
    queue_record(8'h01, 16'h8000, 1'b1);
    queue_record(TAG_BLUE, 16'h0001, 1'b0);
    queue_record(TAG_BLUE, 16'h0002, 1'b0);
    queue_record(TAG_BLUE, 16'h0003, 1'b1);
    queue_record(TAG_GREEN, 16'h7FFF, 1'b0);
    queue_record(TAG_GREEN, 16'h0004, 1'b1);

    // Random sets; one fills the store exactly, one overruns it.
    sets = 0;
    while (record_q.size() < TARGET_ITEMS) begin
      if (sets == 2) begin
        queue_random_set(MAX_RECORDS);
      end else if (sets == 6) begin
        queue_random_set(MAX_RECORDS + 3);
      end else if ($urandom_range(9) == 0) begin
        queue_random_set($urandom_range(13, 24));
      end else begin
        queue_random_set($urandom_range(1, 12));
      end
      sets++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (record_q.size() == 0);
    @(negedge clk);
    while (in_ch.valid) @(negedge clk);
    wait (partitioned_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_beats == 0 && partitioned_q.size() == 0) begin
      $display("PASS three_way_color_partition_top");
    end else begin
      $display("FAIL three_way_color_partition_top");
    end
    $finish;
  end

endmodule

// File: three_way_color_partition_top.f
design/tcp_pkg.sv
design/tcp_ifs.sv
design/tcp_ram.sv
design/tcp_ctrl.sv
design/three_way_color_partition_top.sv
design/tcp_checker.sv
verif/testbench.sv
